// File: sv/integer_to_radix_ascii_macros.svh
// ---------------------------------------------------------------------------
// integer_to_radix_ascii assertion macros
// Shared assertion forms; clk and rst must be in scope where used.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ITRA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ITRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/itra_pkg.sv
// ---------------------------------------------------------------------------
// itra_pkg
// Types, constants and helpers shared by the radix ASCII converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

  localparam int VALUE_W             = 64;
  localparam int RADIX_W             = 6;
  localparam int LEN_W               = 7;
  localparam int CHAR_W              = 8;
  localparam int DIGIT_W             = 6;
  localparam int DEFAULT_MAX_DIGITS  = 64;

  // Long division retires this many quotient bits per clock.
  localparam int DIV_STEPS_PER_CYCLE = 8;
  localparam int DIV_CYCLES          = VALUE_W / DIV_STEPS_PER_CYCLE;
  localparam int DIV_CNT_W           = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'hA;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

  localparam logic CMD_SIGNED   = 1'b0;
  localparam logic CMD_UNSIGNED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_START,
    ST_WAIT,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_TEN) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ch = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/integer_to_radix_ascii.sv
// ---------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a 64-bit value to ASCII text in radix 2..36, one character per
// output beat (a signed request with zero buffer length gives one empty beat).
// Each digit takes a start and a run of the long divider at 8 quotient bits
// per clock, then a write-back of the remainder into the digit RAM; each
// emitted character then takes a digit RAM read and an output load, and a
// leading '-' takes an output load of its own.
// Only one item is in flight; the input stalls until its last beat is loaded
// into the output register, which then holds it until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_ascii_macros.svh"

module integer_to_radix_ascii #(
  parameter int MAX_DIGITS = itra_pkg::DEFAULT_MAX_DIGITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         cmd,
  input  wire logic [itra_pkg::VALUE_W-1:0] value,
  input  wire logic [itra_pkg::RADIX_W-1:0] radix,
  input  wire logic [itra_pkg::LEN_W-1:0]   buffer_length,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [itra_pkg::CHAR_W-1:0]  char_code,
  output logic                              has_char,
  output logic                              last,
  output logic                              truncated,
  output logic      [itra_pkg::LEN_W-1:0]   total_length
);
  import itra_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  state_t             state, state_next;
  logic [VALUE_W-1:0] magnitude, magnitude_next;
  logic               negative_flag, negative_flag_next;
  logic [CNT_W-1:0]   stop, stop_next;
  logic [RADIX_W-1:0] radix_r, radix_r_next;
  logic [CNT_W-1:0]   digit_count, digit_count_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic               trunc, trunc_next;

  logic               out_valid_next;
  logic [CHAR_W-1:0]  char_code_next;
  logic               has_char_next;
  logic               last_next;
  logic               truncated_next;
  logic [LEN_W-1:0]   total_length_next;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [DIGIT_W-1:0] ram_rd_data;

  logic               accept;
  logic               out_free;
  logic [RADIX_W-1:0] radix_clamp;
  logic [LEN_W-1:0]   blen_sat;
  logic [CNT_W-1:0]   count_plus;
  logic [CNT_W-1:0]   rev_idx;
  logic               is_last;

  itra_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  itra_digit_ram #(
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (digit_count[ADDR_W-1:0]),
    .wr_data (div_rsp.remainder),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_clamp = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_clamp = RADIX_MAX;
    end else begin
      radix_clamp = radix;
    end
    if (buffer_length > LEN_W'(MAX_DIGITS)) begin
      blen_sat = LEN_W'(MAX_DIGITS);
    end else begin
      blen_sat = buffer_length;
    end
  end

  assign count_plus  = digit_count + CNT_W'(1);
  assign rev_idx     = digit_count - CNT_W'(1) - idx;
  // truncated text comes out least significant digit first
  assign ram_rd_addr = trunc ? idx[ADDR_W-1:0] : rev_idx[ADDR_W-1:0];
  assign is_last     = (idx == digit_count - CNT_W'(1));

  always_comb begin
    state_next         = state;
    magnitude_next     = magnitude;
    negative_flag_next = negative_flag;
    stop_next          = stop;
    radix_r_next       = radix_r;
    digit_count_next   = digit_count;
    idx_next           = idx;
    trunc_next         = trunc;

    out_valid_next     = out_valid && out_stall;
    char_code_next     = char_code;
    has_char_next      = has_char;
    last_next          = last;
    truncated_next     = truncated;
    total_length_next  = total_length;

    div_req.start      = 1'b0;
    div_req.dividend   = magnitude;
    div_req.divisor    = radix_r;
    ram_wr_en          = 1'b0;
    ram_rd_en          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          radix_r_next     = radix_clamp;
          digit_count_next = '0;
          if (cmd == CMD_SIGNED) begin
            if (buffer_length == '0) begin
              state_next = ST_EMPTY;
            end else begin
              stop_next          = CNT_W'(blen_sat - LEN_W'(1));
              negative_flag_next = value[VALUE_W-1];
              magnitude_next     = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
              state_next         = ST_START;
            end
          end else begin
            stop_next          = CNT_W'(MAX_DIGITS);
            negative_flag_next = 1'b0;
            magnitude_next     = value;
            state_next         = ST_START;
          end
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          char_code_next    = '0;
          has_char_next     = 1'b0;
          last_next         = 1'b1;
          truncated_next    = 1'b0;
          total_length_next = '0;
          state_next        = ST_IDLE;
        end
      end

      ST_START: begin
        div_req.start = 1'b1;
        state_next    = ST_WAIT;
      end

      ST_WAIT: begin
        if (div_rsp.done) begin
          ram_wr_en        = 1'b1;
          digit_count_next = count_plus;
          magnitude_next   = div_rsp.quotient;
          idx_next         = '0;
          if (div_rsp.quotient != '0 && count_plus < stop) begin
            state_next = ST_START;
          end else begin
            trunc_next = (div_rsp.quotient != '0) && (count_plus == stop);
            if (!((div_rsp.quotient != '0) && (count_plus == stop)) && negative_flag) begin
              state_next = ST_SIGN;
            end else begin
              state_next = ST_READ;
            end
          end
        end
      end

      ST_SIGN: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          char_code_next    = CHAR_MINUS;
          has_char_next     = 1'b1;
          last_next         = 1'b0;
          truncated_next    = 1'b0;
          total_length_next = '0;
          state_next        = ST_READ;
        end
      end

      ST_READ: begin
        ram_rd_en  = 1'b1;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          char_code_next = glyph(ram_rd_data);
          has_char_next  = 1'b1;
          last_next      = is_last;
          truncated_next = trunc;
          if (!is_last) begin
            total_length_next = '0;
          end else if (trunc) begin
            total_length_next = LEN_W'(digit_count);
          end else begin
            total_length_next = LEN_W'(digit_count) + LEN_W'(negative_flag);
          end
          if (is_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + CNT_W'(1);
            state_next = ST_READ;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      magnitude     <= '0;
      negative_flag <= 1'b0;
      digit_count   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      magnitude     <= magnitude_next;
      negative_flag <= negative_flag_next;
      digit_count   <= digit_count_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    stop         <= stop_next;
    radix_r      <= radix_r_next;
    idx          <= idx_next;
    trunc        <= trunc_next;
    char_code    <= char_code_next;
    has_char     <= has_char_next;
    last         <= last_next;
    truncated    <= truncated_next;
    total_length <= total_length_next;
  end

  `ITRA_ASSERT_SAME(a_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")
  `ITRA_ASSERT_SAME(a_wr_range, ram_wr_en, digit_count < CNT_W'(MAX_DIGITS), "digit store overflow")
  `ITRA_ASSERT_SAME(a_empty_last, out_valid && !has_char, last && total_length == '0, "bad empty beat")
  `ITRA_ASSERT_SAME(a_trunc_nosign, out_valid && truncated, char_code != CHAR_MINUS, "sign in truncated text")

endmodule

`default_nettype wire

// File: sv/itra_divider.sv
// ---------------------------------------------------------------------------
// itra_divider
// Multi-cycle long division of a 64-bit value by a small radix.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_ascii_macros.svh"

module itra_divider (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire itra_pkg::div_req_t req,
  output itra_pkg::div_rsp_t    rsp
);
  import itra_pkg::*;

  logic [VALUE_W-1:0]   quo;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [VALUE_W-1:0]   q_v;
  logic [DIGIT_W-1:0]   r_v;
  logic [DIGIT_W:0]     t_v;

  // quo shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    q_v = quo;
    r_v = rem;
    t_v = '0;
    for (int i = 0; i < DIV_STEPS_PER_CYCLE; i++) begin
      t_v = {r_v, q_v[VALUE_W-1]};
      q_v = {q_v[VALUE_W-2:0], 1'b0};
      if (t_v >= {1'b0, divisor}) begin
        t_v    = t_v - {1'b0, divisor};
        q_v[0] = 1'b1;
      end
      r_v = t_v[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
      cnt     <= '0;
      busy    <= 1'b1;
      done    <= 1'b0;
    end else if (busy) begin
      quo <= q_v;
      rem <= r_v;
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  `ITRA_ASSERT_NEXT(a_start_busy, req.start, busy, "divider did not start")
  `ITRA_ASSERT_SAME(a_done_idle, done, !busy, "divider done while busy")
  `ITRA_ASSERT_NEXT(a_last_done, busy && !req.start && cnt == DIV_CNT_W'(DIV_CYCLES - 1), done, "divider missed done")

endmodule

`default_nettype wire

// File: sv/itra_digit_ram.sv
// ---------------------------------------------------------------------------
// itra_digit_ram
// Digit store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itra_digit_ram #(
  parameter int DEPTH = itra_pkg::DEFAULT_MAX_DIGITS
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [itra_pkg::DIGIT_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [itra_pkg::DIGIT_W-1:0] rd_data
);
  import itra_pkg::*;

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
